/* design/npm_pkg.sv */
// Package for the nearest point match block: transaction structs, mode codes,
// configuration register indexes and reset values. No dependencies.
`timescale 1ns / 1ps

package npm_pkg;

  // Field widths fixed by the interface
  localparam int unsigned CoordW   = 20;
  localparam int unsigned SizeW    = 14;
  localparam int unsigned LimitW   = 20;
  localparam int unsigned ModeW    = 2;
  localparam int unsigned OutIdxW  = 10;
  localparam int unsigned OutDistW = 41;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 20;

  // Operation codes carried in the mode field
  localparam logic [ModeW-1:0] MODE_CLEAR  = 2'd0;
  localparam logic [ModeW-1:0] MODE_APPEND = 2'd1;
  localparam logic [ModeW-1:0] MODE_QUERY  = 2'd2;
  localparam logic [ModeW-1:0] MODE_UNUSED = 2'd3;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_MATCH_LIMIT  = 2'd2;

  // Register reset values
  localparam logic [SizeW-1:0]  IMAGE_WIDTH_RST  = 14'd2048;
  localparam logic [SizeW-1:0]  IMAGE_HEIGHT_RST = 14'd2048;
  localparam logic [LimitW-1:0] MATCH_LIMIT_RST  = 20'd192;

  typedef struct packed {
    logic [ModeW-1:0]  mode;
    logic [CoordW-1:0] pos_x;
    logic [CoordW-1:0] pos_y;
  } npm_in_t;

  typedef struct packed {
    logic                in_image;
    logic                found;
    logic [OutIdxW-1:0]  best_index;
    logic [OutDistW-1:0] best_dist_sq;
  } npm_out_t;

endpackage

/* design/npm_ram.sv */
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module npm_ram #(
  parameter int unsigned WIDTH = 40,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write on enable, register read data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/nearest_point_match.sv */
// Clear and append transactions never raise busy. A query outside the image interior
// or on an empty catalog returns its result in the cycle after accept. Other queries
// scan one catalog entry per cycle through the read port and the shared squaring unit,
// scanning at most the number of stored entries, and stay busy while scanning.
// Reset is asynchronous and active low; the result strobe cannot be stalled.
`timescale 1ns / 1ps

module nearest_point_match #(
  parameter int unsigned CATALOG_DEPTH   = 1024,
  parameter int unsigned COORD_FRAC_BITS = 6
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  npm_pkg::npm_in_t        in_i,
  output logic                    res_valid_o,
  output npm_pkg::npm_out_t       res_o,
  input  logic                    cfg_we_i,
  input  logic [npm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [npm_pkg::CfgDataW-1:0] cfg_data_i
);

  import npm_pkg::*;

  localparam int unsigned IdxW   = (CATALOG_DEPTH > 1) ? $clog2(CATALOG_DEPTH) : 1;
  localparam int unsigned CntW   = $clog2(CATALOG_DEPTH + 1);
  localparam int unsigned OpW    = (SizeW + COORD_FRAC_BITS > CoordW) ?
                                   (SizeW + COORD_FRAC_BITS) : CoordW;
  localparam int unsigned SqW    = 2 * OpW;
  localparam int unsigned DistW  = SqW + 1;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  // Control state
  logic            state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] issue_q, issue_d;
  logic            rd_vld_q, rd_vld_d;
  logic            op_vld_q, op_vld_d;
  logic            sq_vld_q, sq_vld_d;
  logic            res_valid_q, res_valid_d;

  // Configuration
  logic [SizeW-1:0]  width_q;
  logic [SizeW-1:0]  height_q;
  logic [LimitW-1:0] limit_q;

  // Payload
  logic [CoordW-1:0] px_q, py_q;
  logic [IdxW-1:0]   rd_idx_q;
  logic              op_setup_q, op_setup_d;
  logic [IdxW-1:0]   op_idx_q;
  logic [OpW-1:0]    op_a_q, op_a_d, op_b_q, op_b_d;
  logic              sq_setup_q;
  logic [IdxW-1:0]   sq_idx_q;
  logic [SqW-1:0]    sq_a_q, sq_b_q, sq_a_d, sq_b_d;
  logic [DistW-1:0]  best_q, best_d;
  logic [SqW-1:0]    lim2_q, lim2_d;
  logic [IdxW-1:0]   best_idx_q, best_idx_d;
  logic              found_q, found_d;
  npm_out_t          res_q, res_d;

  // Catalog RAM ports
  logic                   ram_we, ram_re;
  logic [2*CoordW-1:0]    ram_rdata;

  logic accept, in_bounds, issue, finish;

  // Interior bounds in the wider operand format
  logic [OpW-1:0] lo_bound, hi_x, hi_y, px_ext, py_ext;
  logic           in_x, in_y;

  assign accept   = start && (state_q == ST_IDLE);
  assign busy     = (state_q != ST_IDLE);

  assign lo_bound  = OpW'(1) << COORD_FRAC_BITS;
  assign hi_x      = OpW'(width_q - SizeW'(1)) << COORD_FRAC_BITS;
  assign hi_y      = OpW'(height_q - SizeW'(1)) << COORD_FRAC_BITS;
  assign px_ext    = OpW'(in_i.pos_x);
  assign py_ext    = OpW'(in_i.pos_y);
  assign in_x      = (width_q != '0) && (px_ext >= lo_bound) && (px_ext <= hi_x);
  assign in_y      = (height_q != '0) && (py_ext >= lo_bound) && (py_ext <= hi_y);
  assign in_bounds = in_x && in_y;

  // Catalog storage, x in the upper half of each word
  assign ram_we = accept && (in_i.mode == MODE_APPEND) && (cnt_q < CntW'(CATALOG_DEPTH));
  assign ram_re = issue;

  npm_ram #(
    .WIDTH (2 * CoordW),
    .DEPTH (CATALOG_DEPTH)
  ) u_catalog (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q[IdxW-1:0]),
    .wdata_i ({in_i.pos_x, in_i.pos_y}),
    .re_i    (ram_re),
    .raddr_i (issue_q[IdxW-1:0]),
    .rdata_o (ram_rdata)
  );

  // Difference stage: setup token carries radius and limit, entries carry |dx|, |dy|
  logic [CoordW-1:0] rx, ry, dx, dy;
  assign rx = ram_rdata[2*CoordW-1:CoordW];
  assign ry = ram_rdata[CoordW-1:0];
  assign dx = (px_q >= rx) ? (px_q - rx) : (rx - px_q);
  assign dy = (py_q >= ry) ? (py_q - ry) : (ry - py_q);

  always_comb begin
    if (accept) begin
      op_setup_d = 1'b1;
      op_a_d     = OpW'(width_q) << COORD_FRAC_BITS;
      op_b_d     = OpW'(limit_q);
    end else begin
      op_setup_d = 1'b0;
      op_a_d     = OpW'(dx);
      op_b_d     = OpW'(dy);
    end
  end

  // Shared squaring unit
  assign sq_a_d = SqW'(op_a_q) * SqW'(op_a_q);
  assign sq_b_d = SqW'(op_b_q) * SqW'(op_b_q);

  // Evaluate stage: keep the strictly closer entry, stop under the match limit
  logic [DistW-1:0] d2, nb;
  logic             better, last;
  assign d2     = DistW'(sq_a_q) + DistW'(sq_b_q);
  assign better = (d2 < best_q);
  assign nb     = better ? d2 : best_q;
  assign last   = (CntW'(sq_idx_q) == (cnt_q - CntW'(1)));
  assign finish = (state_q == ST_SCAN) && sq_vld_q && !sq_setup_q &&
                  ((nb < DistW'(lim2_q)) || last);

  logic [IdxW+OutIdxW-1:0] idx_wide;
  logic                    nf;
  logic [IdxW-1:0]         nidx;
  assign nf       = found_q || better;
  assign nidx     = better ? sq_idx_q : best_idx_q;
  assign idx_wide = {{OutIdxW{1'b0}}, nidx};

  always_comb begin
    best_d     = best_q;
    lim2_d     = lim2_q;
    best_idx_d = best_idx_q;
    found_d    = found_q;
    if (sq_vld_q) begin
      if (sq_setup_q) begin
        best_d     = DistW'(sq_a_q);
        lim2_d     = sq_b_q;
        best_idx_d = '0;
        found_d    = 1'b0;
      end else begin
        best_d     = nb;
        best_idx_d = nidx;
        found_d    = nf;
      end
    end
  end

  // Sequencer: catalog updates, query launch, read issue, result
  assign issue = (state_q == ST_SCAN) && (issue_q < cnt_q) && !finish;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    issue_d     = issue_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    rd_vld_d    = issue;
    op_vld_d    = rd_vld_q;
    sq_vld_d    = op_vld_q;

    if (accept) begin
      case (in_i.mode)
        MODE_CLEAR: begin
          cnt_d = '0;
        end
        MODE_APPEND: begin
          if (ram_we) begin
            cnt_d = cnt_q + CntW'(1);
          end
        end
        MODE_QUERY: begin
          res_d = '0;
          if (!in_bounds) begin
            res_valid_d = 1'b1;
          end else if (cnt_q == '0) begin
            res_valid_d    = 1'b1;
            res_d.in_image = 1'b1;
          end else begin
            state_d  = ST_SCAN;
            issue_d  = '0;
            op_vld_d = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end

    if (issue) begin
      issue_d = issue_q + CntW'(1);
    end

    // Report and drop whatever is still in flight
    if (finish) begin
      state_d            = ST_IDLE;
      res_valid_d        = 1'b1;
      res_d.in_image     = 1'b1;
      res_d.found        = nf;
      res_d.best_index   = nf ? idx_wide[OutIdxW-1:0] : '0;
      res_d.best_dist_sq = nf ? nb[OutDistW-1:0] : '0;
      rd_vld_d           = 1'b0;
      op_vld_d           = 1'b0;
      sq_vld_d           = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      issue_q     <= '0;
      rd_vld_q    <= 1'b0;
      op_vld_q    <= 1'b0;
      sq_vld_q    <= 1'b0;
      res_valid_q <= 1'b0;
      width_q     <= IMAGE_WIDTH_RST;
      height_q    <= IMAGE_HEIGHT_RST;
      limit_q     <= MATCH_LIMIT_RST;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      issue_q     <= issue_d;
      rd_vld_q    <= rd_vld_d;
      op_vld_q    <= op_vld_d;
      sq_vld_q    <= sq_vld_d;
      res_valid_q <= res_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_IMAGE_WIDTH:  width_q  <= cfg_data_i[SizeW-1:0];
          REG_IMAGE_HEIGHT: height_q <= cfg_data_i[SizeW-1:0];
          REG_MATCH_LIMIT:  limit_q  <= cfg_data_i[LimitW-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      px_q <= in_i.pos_x;
      py_q <= in_i.pos_y;
    end
    rd_idx_q   <= issue_q[IdxW-1:0];
    op_setup_q <= op_setup_d;
    op_idx_q   <= rd_idx_q;
    op_a_q     <= op_a_d;
    op_b_q     <= op_b_d;
    sq_setup_q <= op_setup_q;
    sq_idx_q   <= op_idx_q;
    sq_a_q     <= sq_a_d;
    sq_b_q     <= sq_b_d;
    best_q     <= best_d;
    lim2_q     <= lim2_d;
    best_idx_q <= best_idx_d;
    found_q    <= found_d;
    res_q      <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule
